// ===== rtl/core/mncr_pkg.sv =====
// Shared types and constants for the MIDI note and channel router.
package mncr_pkg;

	// Remap table sizing.
	localparam int MAX_REMAPS = 32;
	localparam int IDX_W      = (MAX_REMAPS > 1) ? $clog2(MAX_REMAPS) : 1;
	localparam int CNT_W      = $clog2(MAX_REMAPS + 1);

	// Configuration register indexes.
	localparam int          CFG_IDX_W        = 1;
	localparam logic [0:0]  REG_IN_FILTER    = 1'd0;
	localparam logic [0:0]  REG_OUT_OVERRIDE = 1'd1;

	// Command opcodes.
	localparam logic [1:0] OP_ROUTE = 2'd0;
	localparam logic [1:0] OP_SET   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Message kinds.
	localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
	localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
	localparam logic [2:0] KIND_POLY_AT  = 3'd2;
	localparam logic [2:0] KIND_CHAN_PRS = 3'd3;

	// Result status codes.
	localparam logic [1:0] ST_FORWARDED = 2'd0;
	localparam logic [1:0] ST_DROPPED   = 2'd1;
	localparam logic [1:0] ST_UPDATED   = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// One command beat.
	typedef struct packed {
		logic [1:0] opcode;
		logic [2:0] msg_kind;
		logic [4:0] msg_channel;
		logic [6:0] data_first;
		logic [6:0] data_second;
		logic [6:0] src_note;
		logic [4:0] src_channel;
		logic [6:0] dst_note;
		logic [4:0] dst_channel;
	} cmd_t;

	// One result beat.
	typedef struct packed {
		logic [1:0] status;
		logic [2:0] out_kind;
		logic [4:0] out_channel;
		logic [6:0] out_data_first;
		logic [6:0] out_data_second;
	} result_t;

	// One stored remap entry.
	typedef struct packed {
		logic [4:0] dst_channel;
		logic [6:0] dst_note;
		logic [4:0] src_channel;
		logic [6:0] src_note;
	} remap_entry_t;

endpackage

// ===== rtl/core/midi_note_channel_router_core.sv =====
// Top level of the MIDI note and channel router with its ordered remap table.
//
// Usage: a command beat on cmd is taken at a rising edge where start is high
// and busy is low. Route commands filter and remap one decoded MIDI message;
// set commands replace or append one remap entry; clear commands empty the
// table. Every command gives exactly one result beat on result, marked by a
// one-cycle done strobe. The receiver cannot stall, so a result is shown once.
// The configuration port (cfg_we, cfg_idx, cfg_wdata) writes the input channel
// filter and the output channel override, with no read-back.
// Timing: the table sits in a memory with one write port and one registered
// read port, and is walked one entry per cycle by one shared entry comparator.
// A routed note message stops the walk at its first matching entry; a set
// command, which never hits, walks every entry; an empty walk and every other
// command go straight from the scan step to the finish step. busy falls in the
// cycle in which done is high, so the next command may be taken there.
// Reset: clears the configuration registers, the entry count and the
// sequencer. Table contents are not cleared; only entries below the count
// are ever read.
module midi_note_channel_router_core
	import mncr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cmd_t                 cmd,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [4:0]           cfg_wdata
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN
	} state_t;

	state_t        state_q;
	logic [4:0]    filter_q;
	logic [4:0]    override_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_q;
	logic [CNT_W-1:0] lim_q;
	logic [CNT_W-1:0] wr_q;
	logic          pend_q;
	logic          pass_q;
	logic          hit_q;
	logic [6:0]    hit_note_q;
	logic [4:0]    hit_chan_q;
	cmd_t          cmd_q;
	logic          done_q;
	result_t       result_q;

	remap_entry_t  mem [MAX_REMAPS];
	remap_entry_t  rdata_s1;

	logic          accept;
	logic          is_set;
	logic          issue;
	logic          ent_match;
	logic          route_hit;
	logic [6:0]    key_note;
	logic [4:0]    key_chan;
	logic          mem_we;
	logic [IDX_W-1:0] mem_waddr;
	remap_entry_t  mem_wdata;
	logic          in_pass;
	logic [2:0]    in_kind;
	cmd_t          cmd_in;
	logic          full;
	logic [4:0]    route_chan;
	logic [4:0]    ovr_chan;
	result_t       fin_result;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;
	assign is_set = (cmd_q.opcode == OP_SET);

	// Filter decision and velocity-zero note-on folding at accept time.
	always_comb begin
		in_pass = (cmd.msg_channel == 5'd0) || (filter_q == 5'd0)
			|| (filter_q == cmd.msg_channel);
		in_kind = cmd.msg_kind;
		if (cmd.msg_kind == KIND_NOTE_ON && cmd.data_second == 7'd0) begin
			in_kind = KIND_NOTE_OFF;
		end
		cmd_in          = cmd;
		cmd_in.msg_kind = in_kind;
	end

	// Shared entry comparator: exact key for set, wildcard channel for route.
	always_comb begin
		key_note  = is_set ? cmd_q.src_note : cmd_q.data_first;
		key_chan  = is_set ? cmd_q.src_channel : cmd_q.msg_channel;
		ent_match = (rdata_s1.src_note == key_note)
			&& ((rdata_s1.src_channel == key_chan)
			|| (!is_set && rdata_s1.src_channel == 5'd0));
	end

	assign route_hit = (state_q == S_SCAN) && pend_q && !is_set && ent_match;
	assign issue     = (state_q == S_SCAN) && (rd_q < lim_q) && !route_hit;
	assign full      = (wr_q >= CNT_W'(MAX_REMAPS));

	// Memory write port: compaction copies during the walk, the append at the end.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_q[IDX_W-1:0];
		mem_wdata = rdata_s1;
		if (state_q == S_SCAN && pend_q && is_set && !ent_match) begin
			mem_we = 1'b1;
		end else if (state_q == S_FIN && is_set && !full) begin
			mem_we    = 1'b1;
			mem_wdata = '{dst_channel: cmd_q.dst_channel, dst_note: cmd_q.dst_note,
				src_channel: cmd_q.src_channel, src_note: cmd_q.src_note};
		end
	end

	// Remap table storage with a registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem[rd_q[IDX_W-1:0]];
	end

	// Result of the finished command.
	always_comb begin
		route_chan = (hit_q && hit_chan_q != 5'd0) ? hit_chan_q : cmd_q.msg_channel;
		ovr_chan   = (override_q != 5'd0) ? override_q : route_chan;
		fin_result = '0;
		case (cmd_q.opcode)
			OP_SET: begin
				fin_result.status = full ? ST_FULL : ST_UPDATED;
			end
			OP_CLEAR: begin
				fin_result.status = ST_UPDATED;
			end
			OP_ROUTE: begin
				if (!pass_q) begin
					fin_result.status = ST_DROPPED;
				end else begin
					fin_result.status          = ST_FORWARDED;
					fin_result.out_kind        = cmd_q.msg_kind;
					fin_result.out_data_first  = cmd_q.data_first;
					fin_result.out_data_second = cmd_q.data_second;
					case (cmd_q.msg_kind) inside
						KIND_NOTE_OFF, KIND_NOTE_ON, KIND_POLY_AT: begin
							fin_result.out_channel = ovr_chan;
							if (hit_q) begin
								fin_result.out_data_first = hit_note_q;
							end
						end
						KIND_CHAN_PRS: begin
							fin_result.out_channel     = ovr_chan;
							fin_result.out_data_second = 7'd0;
						end
						default: begin
							fin_result.out_channel = (cmd_q.msg_channel != 5'd0)
								? ovr_chan : cmd_q.msg_channel;
						end
					endcase
				end
			end
			default: begin
				fin_result.status = ST_DROPPED;
			end
		endcase
	end

	// Sequencer, configuration registers and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			filter_q   <= 5'd0;
			override_q <= 5'd0;
			count_q    <= '0;
			rd_q       <= '0;
			lim_q      <= '0;
			wr_q       <= '0;
			pend_q     <= 1'b0;
			pass_q     <= 1'b0;
			hit_q      <= 1'b0;
			hit_note_q <= 7'd0;
			hit_chan_q <= 5'd0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_IN_FILTER:    filter_q   <= cfg_wdata;
					REG_OUT_OVERRIDE: override_q <= cfg_wdata;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pass_q <= in_pass;
						hit_q  <= 1'b0;
						rd_q   <= '0;
						wr_q   <= '0;
						pend_q <= 1'b0;
						// Only a set or a passing note message walks the table.
						if (cmd.opcode == OP_SET || (cmd.opcode == OP_ROUTE && in_pass
							&& (in_kind == KIND_NOTE_OFF || in_kind == KIND_NOTE_ON
							|| in_kind == KIND_POLY_AT))) begin
							lim_q <= count_q;
						end else begin
							lim_q <= '0;
						end
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					pend_q <= issue;
					if (issue) begin
						rd_q <= rd_q + CNT_W'(1);
					end
					if (mem_we) begin
						wr_q <= wr_q + CNT_W'(1);
					end
					if (route_hit) begin
						hit_q      <= 1'b1;
						hit_note_q <= rdata_s1.dst_note;
						hit_chan_q <= rdata_s1.dst_channel;
					end
					if (route_hit || (!issue && !pend_q)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (cmd_q.opcode == OP_SET) begin
						count_q <= full ? wr_q : wr_q + CNT_W'(1);
					end else if (cmd_q.opcode == OP_CLEAR) begin
						count_q <= '0;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_in;
		end
		if (state_q == S_FIN) begin
			result_q <= fin_result;
		end
	end

	// The entry count never exceeds the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_REMAPS))
		else $error("entry count beyond table size");

	// Compaction never writes ahead of the entry being read.
	a_wr_behind_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (wr_q <= rd_q))
		else $error("compaction write pointer passed read pointer");

	// An accepted command makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("command accepted without going busy");

	// Each result beat lasts one cycle, comes with an idle block and follows the finish step.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(state_q) == S_FIN))
		else $error("done strobe outside the finish step");

	// The walk never reads beyond the valid entries.
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (rd_q < count_q))
		else $error("table read beyond entry count");

endmodule
